// File: hw/rtl/tsdd_pkg.sv
// ----------------------------------------------------------------------------
// tsdd_pkg
// Types and constants shared by the timestamp delta decoder modules.
// ----------------------------------------------------------------------------
package tsdd_pkg;

  localparam int TS_BYTES = 8;

  // decode phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_WIDTH = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  // legal delta widths in bytes
  localparam logic [7:0] DW_1 = 8'd1;
  localparam logic [7:0] DW_2 = 8'd2;
  localparam logic [7:0] DW_4 = 8'd4;
  localparam logic [7:0] DW_8 = 8'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [63:0] timestamp;
    logic        last_of_block;
    logic [1:0]  status;
  } out_t;

  // result of one decode step, handed to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } res_slot_t;

endpackage

// File: hw/rtl/tsdd_core.sv
// ----------------------------------------------------------------------------
// tsdd_core
// Block parser state and the combinational decode step for one input byte.
// ----------------------------------------------------------------------------
module tsdd_core
  import tsdd_pkg::*;
#(
  parameter int COUNT_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_t       in_data,
  output res_slot_t res
);

  localparam int         CW       = 8 * COUNT_BYTES;
  localparam logic [4:0] HDR_CNT0 = 5'(TS_BYTES);
  localparam logic [4:0] HDR_LAST = 5'(TS_BYTES + COUNT_BYTES);

  logic [1:0]    phase, phase_next;
  logic [4:0]    hdr_idx, hdr_idx_next;
  logic [63:0]   running_ts, running_ts_next;
  logic [CW-1:0] item_count, item_count_next;
  logic [3:0]    delta_width, delta_width_next;
  logic [63:0]   delta_shift, delta_shift_next;
  logic [2:0]    dbi, dbi_next;
  logic [CW-1:0] emitted, emitted_next;

  always_comb begin
    logic [7:0]    b;
    logic          fe;
    logic          clr;
    logic [1:0]    clr_phase;
    logic [63:0]   asm_delta;
    logic [63:0]   ext_delta;
    logic [63:0]   sum;
    logic [CW-1:0] em_inc;

    b         = in_data.in_byte;
    fe        = in_data.frame_end;
    clr       = 1'b0;
    clr_phase = PH_HEADER;

    phase_next       = phase;
    hdr_idx_next     = hdr_idx;
    running_ts_next  = running_ts;
    item_count_next  = item_count;
    delta_width_next = delta_width;
    delta_shift_next = delta_shift;
    dbi_next         = dbi;
    emitted_next     = emitted;
    res              = '0;

    asm_delta = delta_shift;
    for (int j = 0; j < 8; j++) begin
      if (dbi == 3'(j)) begin
        asm_delta[8*j +: 8] = b;
      end
    end

    case (delta_width)
      4'd1:    ext_delta = {{56{asm_delta[7]}}, asm_delta[7:0]};
      4'd2:    ext_delta = {{48{asm_delta[15]}}, asm_delta[15:0]};
      4'd4:    ext_delta = {{32{asm_delta[31]}}, asm_delta[31:0]};
      default: ext_delta = asm_delta;
    endcase
    sum    = running_ts + ext_delta;
    em_inc = emitted + CW'(1);

    if (fire) begin
      case (phase)
        PH_HEADER: begin
          if (hdr_idx < HDR_LAST) begin
            for (int j = 0; j < 8; j++) begin
              if (hdr_idx == 5'(j)) begin
                running_ts_next[8*j +: 8] = b;
              end
            end
            for (int j = 0; j < COUNT_BYTES; j++) begin
              if (hdr_idx == HDR_CNT0 + 5'(j)) begin
                item_count_next[8*j +: 8] = b;
              end
            end
            if (fe) begin
              clr        = 1'b1;
              res.valid  = 1'b1;
              res.data   = '{timestamp: '0, last_of_block: 1'b1, status: ST_SHORT};
            end else begin
              hdr_idx_next = hdr_idx + 5'd1;
            end
          end else if (b != DW_1 && b != DW_2 && b != DW_4 && b != DW_8) begin
            clr       = 1'b1;
            clr_phase = fe ? PH_HEADER : PH_SKIP;
            res.valid = 1'b1;
            res.data  = '{timestamp: '0, last_of_block: 1'b1, status: ST_WIDTH};
          end else if (item_count <= CW'(1)) begin
            clr       = 1'b1;
            clr_phase = fe ? PH_HEADER : PH_SKIP;
            res.valid = 1'b1;
            res.data  = '{timestamp: running_ts, last_of_block: 1'b1, status: ST_OK};
          end else if (fe) begin
            clr       = 1'b1;
            res.valid = 1'b1;
            res.data  = '{timestamp: '0, last_of_block: 1'b1, status: ST_TRUNC};
          end else begin
            delta_width_next = b[3:0];
            delta_shift_next = '0;
            dbi_next         = '0;
            emitted_next     = CW'(1);
            hdr_idx_next     = '0;
            phase_next       = PH_BODY;
            res.valid        = 1'b1;
            res.data = '{timestamp: running_ts, last_of_block: 1'b0, status: ST_OK};
          end
        end
        PH_BODY: begin
          if (({1'b0, dbi} + 4'd1) < delta_width) begin
            if (fe) begin
              clr       = 1'b1;
              res.valid = 1'b1;
              res.data  = '{timestamp: '0, last_of_block: 1'b1, status: ST_TRUNC};
            end else begin
              delta_shift_next = asm_delta;
              dbi_next         = dbi + 3'd1;
            end
          end else if (em_inc == item_count) begin
            clr       = 1'b1;
            clr_phase = fe ? PH_HEADER : PH_SKIP;
            res.valid = 1'b1;
            res.data  = '{timestamp: sum, last_of_block: 1'b1, status: ST_OK};
          end else if (fe) begin
            clr       = 1'b1;
            res.valid = 1'b1;
            res.data  = '{timestamp: '0, last_of_block: 1'b1, status: ST_TRUNC};
          end else begin
            running_ts_next  = sum;
            emitted_next     = em_inc;
            delta_shift_next = '0;
            dbi_next         = '0;
            res.valid        = 1'b1;
            res.data = '{timestamp: sum, last_of_block: 1'b0, status: ST_OK};
          end
        end
        default: begin
          // skip to the end of the block
          clr = fe;
        end
      endcase
    end

    if (clr) begin
      phase_next       = clr_phase;
      hdr_idx_next     = '0;
      running_ts_next  = '0;
      item_count_next  = '0;
      delta_width_next = '0;
      delta_shift_next = '0;
      dbi_next         = '0;
      emitted_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_idx     <= '0;
      running_ts  <= '0;
      item_count  <= '0;
      delta_width <= '0;
      delta_shift <= '0;
      dbi         <= '0;
      emitted     <= '0;
    end else begin
      phase       <= phase_next;
      hdr_idx     <= hdr_idx_next;
      running_ts  <= running_ts_next;
      item_count  <= item_count_next;
      delta_width <= delta_width_next;
      delta_shift <= delta_shift_next;
      dbi         <= dbi_next;
      emitted     <= emitted_next;
    end
  end

`ifndef SYNTH
  a_hdr_idx_range: assert property (@(posedge clk) disable iff (rst)
    hdr_idx <= HDR_LAST)
    else $error("header byte index past width byte");

  a_body_width: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> $onehot(delta_width) && ({1'b0, dbi} < delta_width))
    else $error("body state holds an illegal delta width or byte index");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> emitted != '0 && emitted < item_count)
    else $error("body entered with no timestamps owed");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.status != ST_OK |->
      res.data.last_of_block && res.data.timestamp == '0)
    else $error("error result not marked last or carries a timestamp");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.last_of_block |=> phase != PH_BODY && emitted == '0)
    else $error("block state not cleared after final result");
`endif

endmodule

// File: hw/rtl/tsdd_outreg.sv
// ----------------------------------------------------------------------------
// tsdd_outreg
// Result register on the output channel; frees the input side when empty or
// being drained.
// ----------------------------------------------------------------------------
module tsdd_outreg
  import tsdd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  res_slot_t res,
  output logic      take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_data <= res.data;
    end
  end

endmodule

// File: hw/rtl/timestamp_delta_decoder.sv
// ----------------------------------------------------------------------------
// timestamp_delta_decoder
// Byte-serial decoder for delta-compressed 64-bit timestamp blocks.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no gaps of its own: each byte is decoded in
// the cycle it is accepted (a lane write, a sign extend and one 64-bit add)
// and any timestamp it completes appears in the output register on the next
// cycle. Input stalls only while a held result waits for out_ready. A block
// yields the first timestamp after its header byte (8 + COUNT_BYTES + 1
// bytes), then one timestamp per delta group, last_of_block on the final one;
// header, width and truncation faults give a single zero timestamp with
// last_of_block set and a nonzero status.
module timestamp_delta_decoder
  import tsdd_pkg::*;
#(
  parameter int COUNT_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic      fire;
  res_slot_t res;

  assign fire = in_valid && in_ready;

  tsdd_core #(
    .COUNT_BYTES(COUNT_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_data (in_data),
    .res     (res)
  );

  tsdd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .take      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp delta decoder. A short stimulus
// table comes first, then random blocks: mostly well-formed headers and
// delta bodies with random content, plus short headers, bad widths,
// truncated bodies and noise. Every accepted byte runs through a bit-exact
// decoder model, and each result transaction is compared field by field
// with the oldest predicted timestamp. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tsdd_pkg::*;

  localparam int CNT_BYTES = 8;
  localparam int RAND_BYTES = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 30;
  localparam int DIR_ROWS = 25;

  typedef struct {
    in_t  item;
    bit   lit;
    out_t want;
  } row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  row_t byte_q[$];
  out_t pending_ts[$];
  row_t dir_tab[DIR_ROWS];
  bit   cur_lit = 1'b0;
  out_t cur_want = '0;

  int err_cnt = 0;
  int res_n = 0;
  int sent_n = 0;
  int blk_n = 0;
  int cyc = 0;
  int stat_n[4];

  // model state
  logic [1:0]  ph;
  logic [4:0]  hdr_idx;
  logic [63:0] run_ts;
  logic [63:0] cnt;
  logic [3:0]  dw;
  logic [63:0] dshift;
  logic [2:0]  didx;
  logic [63:0] emitted;

  timestamp_delta_decoder #(.COUNT_BYTES(CNT_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_blk();
    ph = PH_HEADER;
    hdr_idx = '0;
    run_ts = '0;
    cnt = '0;
    dw = '0;
    dshift = '0;
    didx = '0;
    emitted = '0;
  endfunction

  function automatic out_t blk_fault(input logic [1:0] st, input bit fe);
    clear_blk();
    if (!fe) ph = (st == ST_WIDTH) ? PH_SKIP : PH_HEADER;
    return {64'd0, 1'b1, st};
  endfunction

  // one accepted byte; returns 1 when it yields a timestamp transaction
  function automatic bit decode_step(input in_t it, output out_t res);
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] ts;
    int unsigned i;
    int unsigned idx;
    int unsigned w;
    int unsigned bits;
    bit fe;
    b = {56'd0, it.in_byte};
    fe = it.frame_end;
    res = '0;
    if (ph == PH_HEADER) begin
      i = 32'(hdr_idx);
      if (i < 8) begin
        run_ts |= b << (8 * i);
      end else if (i < 8 + CNT_BYTES) begin
        cnt |= b << (8 * (i - 8));
      end else begin
        if (it.in_byte != DW_1 && it.in_byte != DW_2 && it.in_byte != DW_4 &&
            it.in_byte != DW_8) begin
          res = blk_fault(ST_WIDTH, fe);
          return 1'b1;
        end
        if (cnt <= 64'd1) begin
          ts = run_ts;
          clear_blk();
          if (!fe) ph = PH_SKIP;
          res = {ts, 1'b1, ST_OK};
          return 1'b1;
        end
        if (fe) begin
          res = blk_fault(ST_TRUNC, 1'b1);
          return 1'b1;
        end
        dw = it.in_byte[3:0];
        dshift = '0;
        didx = '0;
        emitted = 64'd1;
        hdr_idx = '0;
        ph = PH_BODY;
        res = {run_ts, 1'b0, ST_OK};
        return 1'b1;
      end
      if (fe) begin
        res = blk_fault(ST_SHORT, 1'b1);
        return 1'b1;
      end
      hdr_idx = hdr_idx + 5'd1;
      return 1'b0;
    end
    if (ph == PH_BODY) begin
      idx = 32'(didx);
      w = 32'(dw);
      dshift |= b << (8 * idx);
      if (idx + 1 < w) begin
        if (fe) begin
          res = blk_fault(ST_TRUNC, 1'b1);
          return 1'b1;
        end
        didx = didx + 3'd1;
        return 1'b0;
      end
      d = dshift;
      bits = 8 * w;
      if (bits < 64 && d[bits-1]) d |= ~64'd0 << bits;
      run_ts = run_ts + d;
      emitted = emitted + 64'd1;
      dshift = '0;
      didx = '0;
      if (emitted == cnt) begin
        ts = run_ts;
        clear_blk();
        if (!fe) ph = PH_SKIP;
        res = {ts, 1'b1, ST_OK};
        return 1'b1;
      end
      if (fe) begin
        res = blk_fault(ST_TRUNC, 1'b1);
        return 1'b1;
      end
      res = {run_ts, 1'b0, ST_OK};
      return 1'b1;
    end
    // skip phase, and the unused phase behaves the same
    if (fe) clear_blk();
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit fe);
    row_t r;
    r.item = {b, fe};
    r.lit = 1'b0;
    r.want = '0;
    byte_q.insert(byte_q.size(), r);
  endtask

  // first timestamp and count, little-endian, without the width byte
  task automatic push_ts_count(input logic [63:0] ts, input logic [63:0] n);
    for (int k = 0; k < 8; k++) push_byte(ts[8*k +: 8], 1'b0);
    for (int k = 0; k < CNT_BYTES; k++) push_byte(n[8*k +: 8], 1'b0);
  endtask

  function automatic logic [7:0] pick_width();
    case ($urandom_range(3))
      0: return DW_1;
      1: return DW_2;
      2: return DW_4;
      default: return DW_8;
    endcase
  endfunction

  function automatic logic [63:0] pick_ts();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return ~64'd0;
      2: return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_trailer(input int n);
    for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), k == n - 1);
  endtask

  task automatic gen_block();
    int sel;
    int n;
    int trail;
    int mode;
    int body;
    logic [63:0] c;
    logic [7:0] w;
    logic [7:0] b;
    sel = $urandom_range(99);
    blk_n++;
    if (sel < 65) begin
      // well-formed block with random deltas
      mode = $urandom_range(19);
      if (mode < 2) c = 64'(mode);
      else if (mode == 2) c = 64'($urandom_range(11, 40));
      else c = 64'($urandom_range(2, 10));
      w = pick_width();
      trail = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
      push_ts_count(pick_ts(), c);
      push_byte(w, (c <= 1) && (trail == 0));
      for (int k = 1; k < c; k++) begin
        mode = $urandom_range(9);
        for (int j = 0; j < w; j++) begin
          case (mode)
            0: b = 8'hFF;
            1: b = (j == w - 1) ? 8'h80 : 8'h00;
            2: b = (j == w - 1) ? 8'h7F : 8'hFF;
            default: b = 8'($urandom_range(255));
          endcase
          push_byte(b, (k == c - 1) && (j == w - 1) && (trail == 0));
        end
      end
      push_trailer(trail);
    end else if (sel < 73) begin
      // header cut short
      push_trailer($urandom_range(1, 8 + CNT_BYTES));
    end else if (sel < 77) begin
      // noise with stray frame ends, closed by a frame end
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
        push_byte(8'($urandom_range(255)), (k == n - 1) || ($urandom_range(7) == 0));
      end
    end else if (sel < 86) begin
      // bad width byte
      c = ($urandom_range(1) == 0) ? {$urandom, $urandom} : 64'($urandom_range(5));
      push_ts_count(pick_ts(), c);
      case ($urandom_range(4))
        0: w = 8'h00;
        1: w = 8'hFF;
        default: begin
          w = 8'($urandom_range(255));
          while (w == DW_1 || w == DW_2 || w == DW_4 || w == DW_8)
            w = 8'($urandom_range(255));
        end
      endcase
      if ($urandom_range(9) < 3) begin
        push_byte(w, 1'b1);
      end else begin
        push_byte(w, 1'b0);
        push_trailer($urandom_range(1, 4));
      end
    end else begin
      // body truncated by an early frame end
      c = ($urandom_range(3) == 0) ? ({$urandom, $urandom} | 64'h100) :
          64'($urandom_range(2, 12));
      w = pick_width();
      body = (c > 64'd64) ? 41 : (int'(c) - 1) * int'(w);
      n = $urandom_range(0, (body - 1 < 40) ? body - 1 : 40);
      push_ts_count(pick_ts(), c);
      push_byte(w, n == 0);
      push_trailer(n);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d: %s got %h want %h", res_n, what, got, want);
    err_cnt++;
  endtask

  // input side: present the next byte, run the model on every accepted one
  always @(posedge clk) begin : drive_in
    out_t pred;
    bit hit;
    row_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        hit = decode_step(in_data, pred);
        if (cur_lit) pending_ts.insert(pending_ts.size(), cur_want);
        else if (hit) pending_ts.insert(pending_ts.size(), pred);
        sent_n <= sent_n + 1;
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 &&
            ((sent_n >= 350 && sent_n < 600) || $urandom_range(99) >= IDLE_PCT)) begin
          r = byte_q.pop_front();
          in_data <= r.item;
          cur_lit <= r.lit;
          cur_want <= r.want;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= (sent_n >= 350 && sent_n < 600) || ($urandom_range(99) >= IDLE_PCT);
  end

  // output side: each result transaction against the oldest prediction
  always @(posedge clk) begin : check_out
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ts.size() == 0) begin
        report_mismatch("unexpected result, timestamp", out_data.timestamp, 64'd0);
      end else begin
        want = pending_ts.pop_front();
        if (out_data.timestamp !== want.timestamp)
          report_mismatch("timestamp", out_data.timestamp, want.timestamp);
        if (out_data.last_of_block !== want.last_of_block)
          report_mismatch("last_of_block", 64'(out_data.last_of_block),
                          64'(want.last_of_block));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
      end
      stat_n[out_data.status]++;
      res_n++;
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cyc, pending_ts.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int dir_n;
    clear_blk();
    for (int k = 0; k < 4; k++) stat_n[k] = 0;

    dir_tab = '{
      // lone byte with frame end: header too short
      '{'{8'h00, 1'b1}, 1'b1, '{64'd0, 1'b1, ST_SHORT}},
      // all-ones first timestamp
      '{'{8'hFF, 1'b0}, 1'b0, '0}, '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0}, '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0}, '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0}, '{'{8'hFF, 1'b0}, 1'b0, '0},
      // count zero
      '{'{8'h00, 1'b0}, 1'b0, '0}, '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0}, '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0}, '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0}, '{'{8'h00, 1'b0}, 1'b0, '0},
      // widest delta, first timestamp is also the last
      '{'{DW_8, 1'b0}, 1'b1, '{~64'd0, 1'b1, ST_OK}},
      // trailing byte is dropped, its frame end closes the block
      '{'{8'h5A, 1'b1}, 1'b0, '0},
      // header cut after six bytes
      '{'{8'h80, 1'b0}, 1'b0, '0}, '{'{8'h01, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0}, '{'{8'hFE, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1}, 1'b1, '{64'd0, 1'b1, ST_SHORT}}
    };
    foreach (dir_tab[k]) byte_q.insert(byte_q.size(), dir_tab[k]);
    dir_n = byte_q.size();

    while (byte_q.size() < dir_n + RAND_BYTES) gen_block();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_ts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("decoded %0d bytes in %0d random blocks plus a directed table", sent_n, blk_n);
    $display("results: %0d ok, %0d short, %0d bad width, %0d truncated, %0d errors",
             stat_n[ST_OK], stat_n[ST_SHORT], stat_n[ST_WIDTH], stat_n[ST_TRUNC], err_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
